// ===== rtl/core/pee_pkg.sv =====
// ----------------------------------------------------------------------------
// pee_pkg
// shared codes, constants and controller/datapath signal groups
// ----------------------------------------------------------------------------
`default_nettype none
package pee_pkg;

  localparam int VAL_W = 32;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_UNDERFLOW = 3'd1;
  localparam logic [2:0] ST_DROP      = 3'd2;
  localparam logic [2:0] ST_SAT       = 3'd3;
  localparam logic [2:0] ST_DIVZERO   = 3'd4;

  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_MOD   = 8'h25;
  localparam logic [7:0] CH_POW   = 8'h24;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_NEG_ONE = 32'shFFFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_ONE = 32'sd1;

  typedef struct packed {
    logic latch_in;
    logic push_digit;
    logic pop;
    logic latch_a;
    logic latch_b;
    logic alu_start;
    logic push_res;
    logic fin_latch;
  } cmd_t;

  typedef struct packed {
    logic is_digit;
    logic last;
    logic alu_done;
    logic out_busy;
  } stat_t;

  // keep the first error of an expression
  function automatic logic [2:0] note_err(input logic [2:0] cur, input logic [2:0] code);
    note_err = (cur == ST_OK) ? code : cur;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/prefix_expression_evaluator_top.sv =====
// ----------------------------------------------------------------------------
// prefix_expression_evaluator_top
// stack based prefix expression evaluator, one character per input word
// ----------------------------------------------------------------------------
// Characters arrive rightmost first; tlast marks the leftmost one. A digit
// is pushed as it is decoded; an operator pops two operands and runs the
// operator unit: + - and unknown codes in one step, * and $ in a loop with
// one multiply per cycle (at most 32 passes), / and % in a 32-step
// restoring divider. A word with tlast adds a final pop, whose result
// waits until the previous result word has been taken. The result word sits
// in an output register, so the next expression can start while it waits
// to be taken.
`default_nettype none
module prefix_expression_evaluator_top #(
  parameter int STACK_DEPTH = 5
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input words
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,  // [7:0] symbol
  input  wire logic        s_tlast,  // leftmost character
  // result words
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata   // [31:0] value, [34:32] status, rest zero
);

  pee_pkg::cmd_t  cmd;
  pee_pkg::stat_t stat;
  logic [31:0]    value;
  logic [2:0]     status;

  // sequencer
  pee_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // stack, operand registers and operator unit
  pee_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_symbol  (s_tdata),
    .in_last    (s_tlast),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_value  (value),
    .out_status (status)
  );

  // pack result word, padded to whole bytes
  assign m_tdata = {5'd0, status, value};

endmodule
`default_nettype wire

// ===== rtl/core/pee_alu.sv =====
// ----------------------------------------------------------------------------
// pee_alu
// iterative operator unit: add/sub in one step, multiply and power by a
// looped multiplier, divide and remainder by a restoring divider
// ----------------------------------------------------------------------------
`default_nettype none
module pee_alu (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [7:0]  op,
  input  wire logic signed [31:0] a,
  input  wire logic signed [31:0] b,
  output logic             done,
  output logic signed [31:0] res,
  output logic [2:0]       err
);

  typedef enum logic [1:0] {A_IDLE, A_MUL, A_DIV} astate_t;

  astate_t state;
  logic signed [31:0] acc;
  logic [31:0] lim;
  logic [5:0]  iter;
  logic        is_pow;
  logic [31:0] dvs;
  logic [31:0] quo;
  logic [32:0] rem;
  logic [4:0]  cnt;
  logic        is_rem;

  logic signed [63:0] prod;
  logic        prod_ovf;
  logic [5:0]  iter_inc;
  logic [32:0] shv;
  logic        ge;
  logic [32:0] rem_n;
  logic [31:0] quo_n;
  logic [31:0] mag_a;
  logic [31:0] mag_b;
  logic signed [32:0] sum;
  logic signed [32:0] dif;

  assign mag_a = a[31] ? (~a + 32'd1) : a;
  assign mag_b = b[31] ? (~b + 32'd1) : b;
  assign sum = {a[31], a} + {b[31], b};
  assign dif = {a[31], a} - {b[31], b};

  assign prod = acc * a;
  assign prod_ovf = !((&prod[63:31]) || ~(|prod[63:31]));
  assign iter_inc = iter + 6'd1;

  assign shv = {rem[31:0], quo[31]};
  assign ge = shv >= {1'b0, dvs};
  assign rem_n = ge ? (shv - {1'b0, dvs}) : shv;
  assign quo_n = {quo[30:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        A_IDLE: begin
          if (start) begin
            err <= pee_pkg::ST_OK;
            priority case (op)
              pee_pkg::CH_PLUS: begin
                done <= 1'b1;
                if (sum[32] != sum[31]) begin
                  res <= sum[32] ? pee_pkg::VAL_MIN : pee_pkg::VAL_MAX;
                  err <= pee_pkg::ST_SAT;
                end else begin
                  res <= sum[31:0];
                end
              end
              pee_pkg::CH_MINUS: begin
                done <= 1'b1;
                if (dif[32] != dif[31]) begin
                  res <= dif[32] ? pee_pkg::VAL_MIN : pee_pkg::VAL_MAX;
                  err <= pee_pkg::ST_SAT;
                end else begin
                  res <= dif[31:0];
                end
              end
              pee_pkg::CH_MUL: begin
                acc <= b;
                lim <= 32'd1;
                iter <= '0;
                is_pow <= 1'b0;
                state <= A_MUL;
              end
              pee_pkg::CH_DIV, pee_pkg::CH_MOD: begin
                if (b == 32'sd0) begin
                  done <= 1'b1;
                  res <= '0;
                  err <= pee_pkg::ST_DIVZERO;
                end else begin
                  dvs <= mag_b;
                  quo <= mag_a;
                  rem <= '0;
                  cnt <= '0;
                  is_rem <= (op == pee_pkg::CH_MOD);
                  state <= A_DIV;
                end
              end
              pee_pkg::CH_POW: begin
                // trivial bases and exponents finish at once
                if (b == 32'sd0 || a == pee_pkg::VAL_ONE) begin
                  done <= 1'b1;
                  res <= pee_pkg::VAL_ONE;
                end else if (a == pee_pkg::VAL_NEG_ONE) begin
                  done <= 1'b1;
                  res <= b[0] ? pee_pkg::VAL_NEG_ONE : pee_pkg::VAL_ONE;
                end else if (b[31] || a == 32'sd0) begin
                  done <= 1'b1;
                  res <= '0;
                end else begin
                  acc <= pee_pkg::VAL_ONE;
                  lim <= b;
                  iter <= '0;
                  is_pow <= 1'b1;
                  state <= A_MUL;
                end
              end
              default: begin
                done <= 1'b1;
                res <= '0;
              end
            endcase
          end
        end
        A_MUL: begin
          if (prod_ovf) begin
            done <= 1'b1;
            err <= pee_pkg::ST_SAT;
            if (is_pow) begin
              res <= (a[31] && lim[0]) ? pee_pkg::VAL_MIN : pee_pkg::VAL_MAX;
            end else begin
              res <= prod[63] ? pee_pkg::VAL_MIN : pee_pkg::VAL_MAX;
            end
            state <= A_IDLE;
          end else if ({26'd0, iter_inc} == lim) begin
            done <= 1'b1;
            res <= prod[31:0];
            state <= A_IDLE;
          end else begin
            acc <= prod[31:0];
            iter <= iter_inc;
          end
        end
        A_DIV: begin
          rem <= rem_n;
          quo <= quo_n;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            done <= 1'b1;
            state <= A_IDLE;
            if (is_rem) begin
              res <= a[31] ? (~rem_n[31:0] + 32'd1) : rem_n[31:0];
            end else if (a[31] != b[31]) begin
              res <= ~quo_n + 32'd1;
            end else if (quo_n[31]) begin
              res <= pee_pkg::VAL_MAX;
              err <= pee_pkg::ST_SAT;
            end else begin
              res <= quo_n;
            end
          end
        end
        default: state <= A_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/pee_dp.sv =====
// ----------------------------------------------------------------------------
// pee_dp
// datapath: input word register, operand stack, operand registers, operator
// unit and the output word register
// ----------------------------------------------------------------------------
`default_nettype none
module pee_dp #(
  parameter int STACK_DEPTH = 5
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire pee_pkg::cmd_t cmd,
  output pee_pkg::stat_t     stat,
  input  wire logic [7:0]    in_symbol,
  input  wire logic          in_last,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [31:0]        out_value,
  output logic [2:0]         out_status
);

  localparam int PTR_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [PTR_W-1:0] FULL = PTR_W'(STACK_DEPTH);

  logic [31:0] mem [STACK_DEPTH];
  logic [31:0] rd_data;
  logic        rd_empty;
  logic [PTR_W-1:0] top;
  logic [PTR_W-1:0] top_dec;
  logic [2:0]  err;
  logic [7:0]  sym;
  logic        last;
  logic signed [31:0] opa;
  logic signed [31:0] opb;
  logic        alu_done;
  logic signed [31:0] alu_res;
  logic [2:0]  alu_err;
  logic        empty;
  logic        full;
  logic        do_push;
  logic [31:0] push_val;
  logic [31:0] pop_val;

  assign empty = (top == '0);
  assign full = (top >= FULL);
  assign top_dec = top - PTR_W'(1);
  assign pop_val = rd_empty ? pee_pkg::VAL_NEG_ONE : rd_data;
  assign do_push = cmd.push_digit || cmd.push_res;
  assign push_val = cmd.push_digit ? {28'd0, 4'(sym - pee_pkg::CH_ZERO)} : alu_res;

  assign stat.is_digit = (sym >= pee_pkg::CH_ZERO) && (sym <= pee_pkg::CH_NINE);
  assign stat.last = last;
  assign stat.alu_done = alu_done;
  assign stat.out_busy = out_valid && !out_ready;

  pee_alu u_alu (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.alu_start),
    .op    (sym),
    .a     (opa),
    .b     (opb),
    .done  (alu_done),
    .res   (alu_res),
    .err   (alu_err)
  );

  // stack storage, one write and one registered read
  always_ff @(posedge clk) begin
    if (do_push && !full) begin
      mem[top[IDX_W-1:0]] <= push_val;
    end
    if (cmd.pop) begin
      rd_data <= mem[top_dec[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      sym <= in_symbol;
      last <= in_last;
    end
    if (cmd.latch_a) begin
      opa <= pop_val;
    end
    if (cmd.latch_b) begin
      opb <= pop_val;
    end
    if (cmd.fin_latch) begin
      out_value <= pop_val;
      out_status <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top <= '0;
      err <= pee_pkg::ST_OK;
      rd_empty <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.pop) begin
        rd_empty <= empty;
        if (empty) begin
          err <= pee_pkg::note_err(err, pee_pkg::ST_UNDERFLOW);
        end else begin
          top <= top_dec;
        end
      end
      if (do_push) begin
        if (full) begin
          err <= pee_pkg::note_err(
                   pee_pkg::note_err(err, cmd.push_res ? alu_err : pee_pkg::ST_OK),
                   pee_pkg::ST_DROP);
        end else begin
          top <= top + PTR_W'(1);
          err <= pee_pkg::note_err(err, cmd.push_res ? alu_err : pee_pkg::ST_OK);
        end
      end
      if (cmd.fin_latch) begin
        top <= '0;
        err <= pee_pkg::ST_OK;
        out_valid <= 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_top_range: assert property (@(posedge clk) disable iff (rst) top <= FULL)
    else $error("stack pointer beyond depth");
  a_fin_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.fin_latch |=> (top == '0) && (err == pee_pkg::ST_OK) && out_valid)
    else $error("final word did not clear the stack");
  a_drop_err: assert property (@(posedge clk) disable iff (rst)
    (cmd.push_digit && full && !cmd.fin_latch) |=> (err != pee_pkg::ST_OK))
    else $error("dropped push left no error");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/pee_ctrl.sv =====
// ----------------------------------------------------------------------------
// pee_ctrl
// sequencer: decode, pops, operator run, push, final pop and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none
module pee_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire pee_pkg::stat_t stat,
  output pee_pkg::cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_POPB, S_LATB, S_START, S_RUN, S_FPOP, S_FLAT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.is_digit) begin
          cmd.push_digit = 1'b1;
          state_next = stat.last ? S_FPOP : S_IDLE;
        end else begin
          cmd.pop = 1'b1;
          state_next = S_POPB;
        end
      end
      S_POPB: begin
        cmd.latch_a = 1'b1;
        cmd.pop = 1'b1;
        state_next = S_LATB;
      end
      S_LATB: begin
        cmd.latch_b = 1'b1;
        state_next = S_START;
      end
      S_START: begin
        cmd.alu_start = 1'b1;
        state_next = S_RUN;
      end
      S_RUN: begin
        if (stat.alu_done) begin
          cmd.push_res = 1'b1;
          state_next = stat.last ? S_FPOP : S_IDLE;
        end
      end
      S_FPOP: begin
        cmd.pop = 1'b1;
        state_next = S_FLAT;
      end
      S_FLAT: begin
        if (!stat.out_busy) begin
          cmd.fin_latch = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== verif/tb_prefix_expression_evaluator_top.sv =====
// ----------------------------------------------------------------------------
// tb_prefix_expression_evaluator_top
// self-checking bench for the stack based prefix expression evaluator
// ----------------------------------------------------------------------------
// Drives character words (rightmost first, tlast on the leftmost), predicts
// the final value and status of each expression with a behavioral stack
// model, and compares every result word in order. A directed table covers
// the extremes and error cases, then random well-formed expressions and
// noise follow, with random gaps on both sides.
`default_nettype none
module tb_prefix_expression_evaluator_top;

  localparam int DEPTH      = 5;
  localparam int RAND_WORDS = 1600;
  localparam int LIMIT      = 2000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  prefix_expression_evaluator_top #(.STACK_DEPTH(DEPTH)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #1 clk = ~clk;

  typedef struct packed {
    logic signed [31:0] value;
    logic [2:0]         status;
  } eval_res_t;

  // model state of the evaluator
  logic signed [31:0] opnd [DEPTH];
  int unsigned        depth_used;
  logic [2:0]         err_code;

  eval_res_t pending_results[$];
  int        error_count;
  int        cycle_count;
  int        results_seen;
  int        words_sent;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch #%0d at cycle %0d: %s got %0d expected %0d",
             error_count + 1, cycle_count, what, got, want);
    error_count++;
  endtask

  function automatic void flag_err(input logic [2:0] code);
    if (err_code == pee_pkg::ST_OK) err_code = code;
  endfunction

  function automatic void push_opnd(input logic signed [31:0] v);
    if (depth_used >= DEPTH) begin
      flag_err(pee_pkg::ST_DROP);
    end else begin
      opnd[depth_used] = v;
      depth_used++;
    end
  endfunction

  function automatic logic signed [31:0] pop_opnd();
    if (depth_used == 0) begin
      flag_err(pee_pkg::ST_UNDERFLOW);
      return -32'sd1;
    end
    depth_used--;
    return opnd[depth_used];
  endfunction

  function automatic logic signed [31:0] sat32(input longint x);
    if (x > 64'sd2147483647) begin
      flag_err(pee_pkg::ST_SAT);
      return pee_pkg::VAL_MAX;
    end
    if (x < -64'sd2147483648) begin
      flag_err(pee_pkg::ST_SAT);
      return pee_pkg::VAL_MIN;
    end
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] raise_pow(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
    longint acc;
    acc = 1;
    if (b == 0) return 1;
    if (a == 1) return 1;
    if (a == -1) return b[0] ? -32'sd1 : 32'sd1;
    if (b < 0 || a == 0) return 0;
    for (int i = 0; i < b; i++) begin
      acc = acc * longint'(a);
      if (acc > 64'sd2147483647 || acc < -64'sd2147483648) begin
        flag_err(pee_pkg::ST_SAT);
        return (a < 0 && b[0]) ? pee_pkg::VAL_MIN : pee_pkg::VAL_MAX;
      end
    end
    return acc[31:0];
  endfunction

  function automatic logic signed [31:0] apply_op(input logic signed [31:0] a,
                                                  input logic signed [31:0] b,
                                                  input logic [7:0] op);
    longint x, y, r;
    x = a;
    y = b;
    case (op)
      pee_pkg::CH_PLUS:  return sat32(x + y);
      pee_pkg::CH_MINUS: return sat32(x - y);
      pee_pkg::CH_MUL:   return sat32(x * y);
      pee_pkg::CH_DIV: begin
        if (b == 0) begin
          flag_err(pee_pkg::ST_DIVZERO);
          return 0;
        end
        return sat32(x / y);
      end
      pee_pkg::CH_MOD: begin
        if (b == 0) begin
          flag_err(pee_pkg::ST_DIVZERO);
          return 0;
        end
        r = x % y;
        return r[31:0];
      end
      pee_pkg::CH_POW: return raise_pow(a, b);
      default: return 0;
    endcase
  endfunction

  // advance the model by one character, queue a result on the leftmost one
  function automatic void eval_symbol(input logic [7:0] sym, input logic last);
    logic signed [31:0] a, b;
    eval_res_t r;
    if (sym >= pee_pkg::CH_ZERO && sym <= pee_pkg::CH_NINE) begin
      push_opnd(32'(sym - pee_pkg::CH_ZERO));
    end else begin
      a = pop_opnd();
      b = pop_opnd();
      push_opnd(apply_op(a, b, sym));
    end
    if (last) begin
      r.value  = pop_opnd();
      r.status = err_code;
      pending_results.push_back(r);
      depth_used = 0;
      err_code = pee_pkg::ST_OK;
    end
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // send one word and hold it until taken
  task automatic send_word(input logic [7:0] sym, input logic last);
    s_tvalid <= 1'b1;
    s_tdata  <= sym;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    eval_symbol(sym, last);
    words_sent++;
  endtask

  task automatic send_gap(input int n);
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // expected value/status typed in for the readable rows, else predictor only
  typedef struct {
    logic [7:0]         sym;
    logic               last;
    logic               typed;
    logic signed [31:0] want_value;
    logic [2:0]         want_status;
  } dir_row_t;

  dir_row_t dir_rows[$];
  logic [7:0] operators[7] = '{pee_pkg::CH_PLUS, pee_pkg::CH_MINUS, pee_pkg::CH_MUL,
                               pee_pkg::CH_DIV, pee_pkg::CH_MOD, pee_pkg::CH_POW, 8'h41};

  function automatic void add_row(input logic [7:0] s, input logic l, input logic t = 1'b0,
                                  input logic signed [31:0] v = 0, input logic [2:0] st = 0);
    dir_row_t r;
    r.sym = s; r.last = l; r.typed = t; r.want_value = v; r.want_status = st;
    dir_rows.push_back(r);
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(pee_pkg::CH_ZERO + $urandom_range(0, 9));
  endfunction

  // result side: random stall and compare with oldest expectation
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, value", $signed(m_tdata[31:0]), 0);
      end else begin
        eval_res_t w;
        w = pending_results.pop_front();
        results_seen <= results_seen + 1;
        if ($signed(m_tdata[31:0]) != w.value)
          report_mismatch("value", $signed(m_tdata[31:0]), w.value);
        if (m_tdata[34:32] != w.status)
          report_mismatch("status", m_tdata[34:32], w.status);
        if (m_tdata[39:35] != 0)
          report_mismatch("padding", m_tdata[39:35], 0);
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if ((cycle_count / 3000) % 4 == 1) begin
      m_tready <= 1'b1;  // stretch with no stalls
    end else begin
      stall_left <= pick_gap();
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (cycle_count > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int nops, n, typed_rows;
    logic signed [31:0] got_v;
    error_count = 0; cycle_count = 0; results_seen = 0; words_sent = 0;
    depth_used = 0; err_code = pee_pkg::ST_OK;

    // directed table: rows read rightmost char first
    add_row(pee_pkg::CH_ZERO, 1'b1, 1'b1, 0, pee_pkg::ST_OK);          // lone 0
    add_row(pee_pkg::CH_NINE, 1'b1, 1'b1, 9, pee_pkg::ST_OK);          // lone 9
    add_row(pee_pkg::CH_PLUS, 1'b1, 1'b1, -2, pee_pkg::ST_UNDERFLOW);  // op on empty stack
    for (int i = 0; i < 6; i++) add_row(pee_pkg::CH_NINE, 1'b0);       // sixth push dropped
    add_row(pee_pkg::CH_NINE, 1'b1, 1'b1, 9, pee_pkg::ST_DROP);
    foreach (operators[k]) begin                              // every operator and an unknown code on 7,2
      add_row(8'd50, 1'b0);
      add_row(8'd55, 1'b0);
      add_row(operators[k], 1'b1);
    end
    add_row(pee_pkg::CH_ZERO, 1'b0);                          // 9/0
    add_row(pee_pkg::CH_NINE, 1'b0);
    add_row(pee_pkg::CH_DIV, 1'b1, 1'b1, 0, pee_pkg::ST_DIVZERO);
    add_row(pee_pkg::CH_NINE, 1'b0);                          // 9^(9+9) saturates
    add_row(pee_pkg::CH_NINE, 1'b0);
    add_row(pee_pkg::CH_PLUS, 1'b0);
    add_row(pee_pkg::CH_NINE, 1'b0);
    add_row(pee_pkg::CH_POW, 1'b1, 1'b1, pee_pkg::VAL_MAX, pee_pkg::ST_SAT);
    add_row(8'hFF, 1'b1, 1'b1, 0, pee_pkg::ST_UNDERFLOW);    // all-ones symbol

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    typed_rows = 0;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].typed) typed_rows++;
      send_word(dir_rows[i].sym, dir_rows[i].last);
      if (dir_rows[i].typed) begin
        got_v = pending_results[pending_results.size()-1].value;
        if (got_v != dir_rows[i].want_value)
          report_mismatch("table value", got_v, dir_rows[i].want_value);
        if (pending_results[pending_results.size()-1].status != dir_rows[i].want_status)
          report_mismatch("table status",
                          pending_results[pending_results.size()-1].status,
                          dir_rows[i].want_status);
      end
      send_gap(pick_gap());
    end

    // hold off until everything drains
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);

    // random expressions; with 2 operands per op the stack stays in range
    while (words_sent < RAND_WORDS + dir_rows.size()) begin
      n = $urandom_range(0, 99);
      if (n < 75) begin
        // well-formed: nops operators, values built bottom up
        nops = $urandom_range(0, 3);
        send_word(rand_digit(), nops == 0);
        for (int j = 0; j < nops; j++) begin
          send_gap(pick_gap());
          send_word(rand_digit(), 1'b0);
          send_gap(pick_gap());
          send_word($urandom_range(0, 5) == 0 ?
                      8'(pee_pkg::CH_MOD + $urandom_range(0, 1) * 3)
                    : operators[$urandom_range(0, 5)],
                    j == nops - 1);
        end
      end else begin
        // noise: arbitrary characters, random length
        nops = $urandom_range(1, 8);
        for (int j = 0; j < nops; j++) begin
          send_word(8'($urandom_range(0, 255)), j == nops - 1);
          send_gap(pick_gap());
        end
      end
      send_gap(pick_gap());
    end

    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("sent %0d character words, checked %0d results (%0d typed rows)",
             words_sent, results_seen, typed_rows);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/core/pee_pkg.sv
rtl/core/pee_alu.sv
rtl/core/pee_dp.sv
rtl/core/pee_ctrl.sv
rtl/core/prefix_expression_evaluator_top.sv
verif/tb_prefix_expression_evaluator_top.sv
